// File: rtl/pvfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar velocity frame rotator package
// Shared operation codes, fixed-point constants and the CORDIC arctangent
// table used by all stages of the rotator pipeline.
// ----------------------------------------------------------------------------
package pvfr_pkg;

    // Default configuration handed to the top level parameters.
    localparam int VELOCITY_BITS_DEF   = 18;
    localparam int ANGLE_BITS_DEF      = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    // Fraction bits kept below the velocity LSB inside the rotator.
    localparam int GUARD_BITS = 16;

    // Angles are carried internally as 32-bit turns, residual one bit wider.
    localparam int TURN_BITS = 32;
    localparam int Z_BITS    = TURN_BITS + 1;

    // CORDIC gain correction 0.60725293... in Q30, and its shift.
    localparam int                 GAIN_BITS  = 31;
    localparam int                 GAIN_SHIFT = 30 - GUARD_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_FIX = 31'd652032874;

    // Number of arctangent entries available.
    localparam int ATAN_ENTRIES = 24;

    typedef enum logic [1:0] {
        OP_BODY_TO_NAV   = 2'd0,
        OP_NAV_TO_BODY   = 2'd1,
        OP_SPEED_HEADING = 2'd2,
        OP_NONE          = 2'd3
    } op_t;

    // atan(2^-i) in 32-bit turn units, rounded.
    function automatic logic [TURN_BITS-1:0] atan_turn(input int idx);
        logic [TURN_BITS-1:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/planar_velocity_frame_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar velocity frame rotator
// Pipelined CORDIC that turns a planar velocity between body and navigation
// frames, or a speed along a heading into east and north components.
// ----------------------------------------------------------------------------
// Usage:
// Each input transaction on the s_ channel carries the operation in s_tuser
// and the two Q10.8 components and the binary angle in s_tdata. Each input
// transaction produces exactly one output transaction on the m_ channel,
// carrying the two rounded, saturated Q11.8 results, in input order.
// The pipeline is an input stage (operation decode and quadrant fold), a
// gain-correction multiply stage, one register stage per CORDIC iteration
// and a rounding stage that doubles as the output register. Every stage
// can take a new transaction in every cycle while m_tready is high, so
// sustained throughput is one transaction per clock without back pressure;
// the gain-correction multiply is the deepest stage and sets the clock
// limit.
// When the receiver holds m_tready low, each stage holding data keeps it and
// stops only if the stage after it is full; s_tready drops only after the
// whole pipeline has filled. Nothing is lost or repeated across a stall.
// A synchronous reset (aresetn low) empties the pipeline; the block keeps
// no other state and needs no configuration.
// ----------------------------------------------------------------------------
module planar_velocity_frame_rotator #(
    parameter int VELOCITY_BITS   = pvfr_pkg::VELOCITY_BITS_DEF,
    parameter int ANGLE_BITS      = pvfr_pkg::ANGLE_BITS_DEF,
    parameter int ROTATION_STAGES = pvfr_pkg::ROTATION_STAGES_DEF,
    localparam int IN_W     = 2 * VELOCITY_BITS + ANGLE_BITS,
    localparam int IN_BYTES = (IN_W + 7) / 8,
    localparam int OUT_W    = 2 * (VELOCITY_BITS + 1),
    localparam int OUT_BYTES = (OUT_W + 7) / 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0 up: first_component, second_component, angle, zero padding.
    input  logic [8*IN_BYTES-1:0]  s_tdata,
    // From bit 0 up: operation.
    input  logic [1:0]             s_tuser,
    // Result channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0 up: result_first, result_second, zero padding.
    output logic [8*OUT_BYTES-1:0] m_tdata
);

    localparam int DATA_W = VELOCITY_BITS + pvfr_pkg::GUARD_BITS + 3;
    localparam int ZW     = pvfr_pkg::Z_BITS;
    localparam int OW     = VELOCITY_BITS + 1;

    // Unpack the input transaction.
    logic signed [VELOCITY_BITS-1:0] in_first, in_second;
    logic        [ANGLE_BITS-1:0]    in_angle;
    pvfr_pkg::op_t                   in_op;

    assign in_first  = s_tdata[VELOCITY_BITS-1:0];
    assign in_second = s_tdata[2*VELOCITY_BITS-1:VELOCITY_BITS];
    assign in_angle  = s_tdata[IN_W-1:2*VELOCITY_BITS];
    assign in_op     = pvfr_pkg::op_t'(s_tuser);

    // Input stage to gain stage.
    logic                         pre_valid, pre_ready;
    pvfr_pkg::op_t                pre_op;
    logic signed [VELOCITY_BITS:0] pre_p, pre_q;
    logic signed [ZW-1:0]         pre_z;

    // Chain through the gain stage and the CORDIC iterations; index 0 is the
    // gain stage output, index i+1 the output of iteration i.
    logic                     stg_valid [ROTATION_STAGES+1];
    logic                     stg_ready [ROTATION_STAGES+1];
    pvfr_pkg::op_t            stg_op    [ROTATION_STAGES+1];
    logic signed [DATA_W-1:0] stg_p     [ROTATION_STAGES+1];
    logic signed [DATA_W-1:0] stg_q     [ROTATION_STAGES+1];
    logic signed [ZW-1:0]     stg_z     [ROTATION_STAGES+1];

    logic                 fin_ready;
    pvfr_pkg::op_t        out_op;
    logic signed [OW-1:0] out_first, out_second;

    pvfr_pre #(
        .VELOCITY_BITS (VELOCITY_BITS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_pre (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_i  (s_tvalid),
        .ready_o  (s_tready),
        .op_i     (in_op),
        .first_i  (in_first),
        .second_i (in_second),
        .angle_i  (in_angle),
        .valid_o  (pre_valid),
        .ready_i  (pre_ready),
        .op_o     (pre_op),
        .p_o      (pre_p),
        .q_o      (pre_q),
        .z_o      (pre_z)
    );

    pvfr_gain #(
        .VELOCITY_BITS (VELOCITY_BITS),
        .DATA_W        (DATA_W)
    ) u_gain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (pre_valid),
        .ready_o (pre_ready),
        .op_i    (pre_op),
        .p_i     (pre_p),
        .q_i     (pre_q),
        .z_i     (pre_z),
        .valid_o (stg_valid[0]),
        .ready_i (stg_ready[0]),
        .op_o    (stg_op[0]),
        .p_o     (stg_p[0]),
        .q_o     (stg_q[0]),
        .z_o     (stg_z[0])
    );

    for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_iter
        pvfr_stage #(
            .DATA_W (DATA_W),
            .STAGE  (i)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (stg_valid[i]),
            .ready_o (stg_ready[i]),
            .op_i    (stg_op[i]),
            .p_i     (stg_p[i]),
            .q_i     (stg_q[i]),
            .z_i     (stg_z[i]),
            .valid_o (stg_valid[i+1]),
            .ready_i (stg_ready[i+1]),
            .op_o    (stg_op[i+1]),
            .p_o     (stg_p[i+1]),
            .q_o     (stg_q[i+1]),
            .z_o     (stg_z[i+1])
        );
    end

    // The residual angle of the last iteration has no further use.
    assign stg_ready[ROTATION_STAGES] = fin_ready;

    pvfr_round #(
        .VELOCITY_BITS (VELOCITY_BITS),
        .DATA_W        (DATA_W)
    ) u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_i  (stg_valid[ROTATION_STAGES]),
        .ready_o  (fin_ready),
        .op_i     (stg_op[ROTATION_STAGES]),
        .p_i      (stg_p[ROTATION_STAGES]),
        .q_i      (stg_q[ROTATION_STAGES]),
        .valid_o  (m_tvalid),
        .ready_i  (m_tready),
        .op_o     (out_op),
        .first_o  (out_first),
        .second_o (out_second)
    );

    // Pack the result transaction, padding with zeros to whole bytes.
    assign m_tdata = {{(8*OUT_BYTES - OUT_W){1'b0}}, out_second, out_first};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Back pressure reaches the input only when the output is full and stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output register could move");

    // An accepted transaction always lands in the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> pre_valid)
        else $error("accepted transaction lost at the input stage");

    // The unused operation code yields an all-zero result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_op == pvfr_pkg::OP_NONE)) |-> (m_tdata == '0))
        else $error("unused operation produced a nonzero result");

endmodule

// File: rtl/pvfr_pre.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotator input stage
// Decodes the operation, orders the components, forms the 32-bit turn and
// folds the angle into the CORDIC convergence range.
// ----------------------------------------------------------------------------
module pvfr_pre #(
    parameter int VELOCITY_BITS = pvfr_pkg::VELOCITY_BITS_DEF,
    parameter int ANGLE_BITS    = pvfr_pkg::ANGLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              valid_i,
    output logic                              ready_o,
    input  pvfr_pkg::op_t                     op_i,
    input  logic signed [VELOCITY_BITS-1:0]   first_i,
    input  logic signed [VELOCITY_BITS-1:0]   second_i,
    input  logic        [ANGLE_BITS-1:0]      angle_i,
    output logic                              valid_o,
    input  logic                              ready_i,
    output pvfr_pkg::op_t                     op_o,
    output logic signed [VELOCITY_BITS:0]     p_o,
    output logic signed [VELOCITY_BITS:0]     q_o,
    output logic signed [pvfr_pkg::Z_BITS-1:0] z_o
);

    localparam int PW = VELOCITY_BITS + 1;
    localparam int TW = pvfr_pkg::TURN_BITS;

    logic                  valid_reg;
    pvfr_pkg::op_t         op_reg;
    logic signed [PW-1:0]  p_reg, p_next;
    logic signed [PW-1:0]  q_reg, q_next;
    logic signed [pvfr_pkg::Z_BITS-1:0] z_reg, z_next;

    logic [TW-1:0]        turn_fwd;
    logic [TW-1:0]        turn_sel;
    logic [TW-1:0]        turn_fold;
    logic signed [PW-1:0] p_raw, q_raw;
    logic                 flip;

    assign turn_fwd = {angle_i, {(TW - ANGLE_BITS){1'b0}}};

    always_comb begin
        unique case (op_i)
            pvfr_pkg::OP_BODY_TO_NAV: begin
                p_raw    = PW'(first_i);
                q_raw    = PW'(second_i);
                turn_sel = turn_fwd;
            end
            pvfr_pkg::OP_NAV_TO_BODY: begin
                p_raw    = PW'(second_i);
                q_raw    = PW'(first_i);
                turn_sel = TW'(0) - turn_fwd;
            end
            pvfr_pkg::OP_SPEED_HEADING: begin
                p_raw    = PW'(first_i);
                q_raw    = '0;
                turn_sel = turn_fwd;
            end
            default: begin
                p_raw    = '0;
                q_raw    = '0;
                turn_sel = '0;
            end
        endcase

        // Second and third quadrants: turn the vector half way round first.
        flip      = turn_sel[TW-1] ^ turn_sel[TW-2];
        turn_fold = {turn_sel[TW-1] ^ flip, turn_sel[TW-2:0]};
        p_next    = flip ? -p_raw : p_raw;
        q_next    = flip ? -q_raw : q_raw;
        z_next    = {turn_fold[TW-1], turn_fold};
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            op_reg <= op_i;
            p_reg  <= p_next;
            q_reg  <= q_next;
            z_reg  <= z_next;
        end
    end

    assign valid_o = valid_reg;
    assign op_o    = op_reg;
    assign p_o     = p_reg;
    assign q_o     = q_reg;
    assign z_o     = z_reg;

endmodule

// File: rtl/pvfr_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotator gain stage
// Scales both components by the CORDIC gain correction and moves them onto
// the guarded internal fixed-point grid.
// ----------------------------------------------------------------------------
module pvfr_gain #(
    parameter int VELOCITY_BITS = pvfr_pkg::VELOCITY_BITS_DEF,
    parameter int DATA_W        = VELOCITY_BITS + pvfr_pkg::GUARD_BITS + 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               valid_i,
    output logic                               ready_o,
    input  pvfr_pkg::op_t                      op_i,
    input  logic signed [VELOCITY_BITS:0]      p_i,
    input  logic signed [VELOCITY_BITS:0]      q_i,
    input  logic signed [pvfr_pkg::Z_BITS-1:0] z_i,
    output logic                               valid_o,
    input  logic                               ready_i,
    output pvfr_pkg::op_t                      op_o,
    output logic signed [DATA_W-1:0]           p_o,
    output logic signed [DATA_W-1:0]           q_o,
    output logic signed [pvfr_pkg::Z_BITS-1:0] z_o
);

    localparam int MW = VELOCITY_BITS + 1 + pvfr_pkg::GAIN_BITS + 1;
    localparam logic signed [pvfr_pkg::GAIN_BITS:0] Gain = {1'b0, pvfr_pkg::GAIN_FIX};

    logic                     valid_reg;
    pvfr_pkg::op_t            op_reg;
    logic signed [DATA_W-1:0] p_reg, q_reg;
    logic signed [pvfr_pkg::Z_BITS-1:0] z_reg;

    logic signed [MW-1:0] p_prod, q_prod;
    logic signed [MW-1:0] p_shift, q_shift;

    assign p_prod  = p_i * Gain;
    assign q_prod  = q_i * Gain;
    assign p_shift = p_prod >>> pvfr_pkg::GAIN_SHIFT;
    assign q_shift = q_prod >>> pvfr_pkg::GAIN_SHIFT;

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            op_reg <= op_i;
            p_reg  <= p_shift[DATA_W-1:0];
            q_reg  <= q_shift[DATA_W-1:0];
            z_reg  <= z_i;
        end
    end

    assign valid_o = valid_reg;
    assign op_o    = op_reg;
    assign p_o     = p_reg;
    assign q_o     = q_reg;
    assign z_o     = z_reg;

endmodule

// File: rtl/pvfr_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotator micro-rotation stage
// One CORDIC iteration: shift-and-add rotation steered by the sign of the
// residual angle, with the fixed arctangent for this stage.
// ----------------------------------------------------------------------------
module pvfr_stage #(
    parameter int DATA_W = pvfr_pkg::VELOCITY_BITS_DEF + pvfr_pkg::GUARD_BITS + 3,
    parameter int STAGE  = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               valid_i,
    output logic                               ready_o,
    input  pvfr_pkg::op_t                      op_i,
    input  logic signed [DATA_W-1:0]           p_i,
    input  logic signed [DATA_W-1:0]           q_i,
    input  logic signed [pvfr_pkg::Z_BITS-1:0] z_i,
    output logic                               valid_o,
    input  logic                               ready_i,
    output pvfr_pkg::op_t                      op_o,
    output logic signed [DATA_W-1:0]           p_o,
    output logic signed [DATA_W-1:0]           q_o,
    output logic signed [pvfr_pkg::Z_BITS-1:0] z_o
);

    localparam logic signed [pvfr_pkg::Z_BITS-1:0] Atan =
        {1'b0, pvfr_pkg::atan_turn(STAGE)};

    logic                     valid_reg;
    pvfr_pkg::op_t            op_reg;
    logic signed [DATA_W-1:0] p_reg, p_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic signed [pvfr_pkg::Z_BITS-1:0] z_reg, z_next;

    logic signed [DATA_W-1:0] dp, dq;

    assign dp = q_i >>> STAGE;
    assign dq = p_i >>> STAGE;

    always_comb begin
        if (!z_i[pvfr_pkg::Z_BITS-1]) begin
            p_next = p_i - dp;
            q_next = q_i + dq;
            z_next = z_i - Atan;
        end else begin
            p_next = p_i + dp;
            q_next = q_i - dq;
            z_next = z_i + Atan;
        end
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            op_reg <= op_i;
            p_reg  <= p_next;
            q_reg  <= q_next;
            z_reg  <= z_next;
        end
    end

    assign valid_o = valid_reg;
    assign op_o    = op_reg;
    assign p_o     = p_reg;
    assign q_o     = q_reg;
    assign z_o     = z_reg;

endmodule

// File: rtl/pvfr_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotator output stage
// Rounds away the guard bits, saturates, orders the two results for the
// operation and holds them in the output register.
// ----------------------------------------------------------------------------
module pvfr_round #(
    parameter int VELOCITY_BITS = pvfr_pkg::VELOCITY_BITS_DEF,
    parameter int DATA_W        = VELOCITY_BITS + pvfr_pkg::GUARD_BITS + 3
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           valid_i,
    output logic                           ready_o,
    input  pvfr_pkg::op_t                  op_i,
    input  logic signed [DATA_W-1:0]       p_i,
    input  logic signed [DATA_W-1:0]       q_i,
    output logic                           valid_o,
    input  logic                           ready_i,
    output pvfr_pkg::op_t                  op_o,
    output logic signed [VELOCITY_BITS:0]  first_o,
    output logic signed [VELOCITY_BITS:0]  second_o
);

    localparam int OW = VELOCITY_BITS + 1;
    localparam int RW = DATA_W - pvfr_pkg::GUARD_BITS;
    localparam logic signed [DATA_W-1:0] RoundHalf =
        DATA_W'(1) << (pvfr_pkg::GUARD_BITS - 1);
    localparam logic signed [RW-1:0] SatHi =
        {{(RW - VELOCITY_BITS){1'b0}}, {VELOCITY_BITS{1'b1}}};
    localparam logic signed [RW-1:0] SatLo =
        {{(RW - VELOCITY_BITS){1'b1}}, {VELOCITY_BITS{1'b0}}};

    function automatic logic signed [OW-1:0] round_sat(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] sum;
        logic signed [RW-1:0]     r;
        logic signed [OW-1:0]     res;
        sum = v + RoundHalf;
        r   = sum[DATA_W-1:pvfr_pkg::GUARD_BITS];
        if (r > SatHi) begin
            res = SatHi[OW-1:0];
        end else if (r < SatLo) begin
            res = SatLo[OW-1:0];
        end else begin
            res = r[OW-1:0];
        end
        return res;
    endfunction

    logic                  valid_reg;
    pvfr_pkg::op_t         op_reg;
    logic signed [OW-1:0]  first_reg, first_next;
    logic signed [OW-1:0]  second_reg, second_next;
    logic signed [OW-1:0]  p_fin, q_fin;

    assign p_fin = round_sat(p_i);
    assign q_fin = round_sat(q_i);

    always_comb begin
        unique case (op_i)
            pvfr_pkg::OP_BODY_TO_NAV, pvfr_pkg::OP_SPEED_HEADING: begin
                first_next  = q_fin;
                second_next = p_fin;
            end
            pvfr_pkg::OP_NAV_TO_BODY: begin
                first_next  = p_fin;
                second_next = q_fin;
            end
            default: begin
                first_next  = '0;
                second_next = '0;
            end
        endcase
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            op_reg     <= op_i;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign valid_o  = valid_reg;
    assign op_o     = op_reg;
    assign first_o  = first_reg;
    assign second_o = second_reg;

endmodule
